@@ rtl/first_fit_coalescing_allocator_core_macros.svh @@
// Assertion macros for the first-fit allocator core.
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FFCA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, checked out of reset.
`define FFCA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

@@ rtl/ffca_pkg.sv @@
// Shared constants, codes and control types of the allocator core.
`timescale 1ns / 1ps
package ffca_pkg;

    localparam int FREE_ENTRIES_DEF    = 64;
    localparam int LIVE_ENTRIES_DEF    = 64;
    localparam int HEADER_BYTES_DEF    = 8;
    localparam int MIN_BLOCK_BYTES_DEF = 8;
    // Push order stamp; larger means nearer the list head.
    localparam int STAMP_W             = 40;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_ADD   = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_SIZE   = 3'd1,
        ST_NOFIT  = 3'd2,
        ST_BADPTR = 3'd3,
        ST_FULL   = 3'd4
    } t_status;

    typedef struct packed {
        logic load;
        logic check;
        logic sweep_start;
        logic sweep_run;
        logic apply;
        logic merge_apply;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic pre_err;
        logic sweep_done;
        logic go_merge;
    } t_stat;

endpackage

@@ rtl/ffca_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ffca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/ffca_ctrl.sv @@
// Sequencer of the allocator core: check, table sweeps, updates, result hand-off.
`timescale 1ns / 1ps
module ffca_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  ffca_pkg::t_stat i_stat,
    output ffca_pkg::t_cmd  o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHECK  = 7'b0000010,
        S_SWEEP  = 7'b0000100,
        S_APPLY  = 7'b0001000,
        S_MSWEEP = 7'b0010000,
        S_MAPPLY = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_pass, n_pass;

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_stat.op == ffca_pkg::OP_NONE || i_stat.pre_err) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.sweep_start = 1'b1;
                    n_state           = S_SWEEP;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_run = 1'b1;
                if (i_stat.sweep_done) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                if (i_stat.go_merge) begin
                    o_cmd.sweep_start = 1'b1;
                    n_pass            = 1'b0;
                    n_state           = S_MSWEEP;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MSWEEP: begin
                o_cmd.sweep_run = 1'b1;
                if (i_stat.sweep_done) begin
                    n_state = S_MAPPLY;
                end
            end
            S_MAPPLY: begin
                o_cmd.merge_apply = 1'b1;
                if (!r_pass) begin
                    // second merge pass on the grown extent
                    o_cmd.sweep_start = 1'b1;
                    n_pass            = 1'b1;
                    n_state           = S_MSWEEP;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
endmodule

@@ rtl/ffca_dp.sv @@
// Datapath of the allocator core: tables, sweep scanner, size math, updates.
`timescale 1ns / 1ps
module ffca_dp #(
    parameter int FREE_ENTRIES    = ffca_pkg::FREE_ENTRIES_DEF,
    parameter int LIVE_ENTRIES    = ffca_pkg::LIVE_ENTRIES_DEF,
    parameter int HEADER_BYTES    = ffca_pkg::HEADER_BYTES_DEF,
    parameter int MIN_BLOCK_BYTES = ffca_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_operation,
    input  logic [31:0]     i_request_bytes,
    input  logic [31:0]     i_address,
    input  ffca_pkg::t_cmd  i_cmd,
    output ffca_pkg::t_stat o_stat,
    output logic [31:0]     o_result_address,
    output logic [2:0]      o_status
);
    localparam int FAW     = $clog2(FREE_ENTRIES);
    localparam int LAW     = $clog2(LIVE_ENTRIES);
    localparam int SWEEP_N = (FREE_ENTRIES > LIVE_ENTRIES) ? FREE_ENTRIES : LIVE_ENTRIES;
    localparam int SW      = $clog2(SWEEP_N + 1);
    localparam int STW     = ffca_pkg::STAMP_W;
    localparam int EW      = STW + 64;

    // latched item
    ffca_pkg::t_op    r_op;
    logic [31:0]      r_req, r_addr, r_size;

    // result
    logic [31:0]      r_res;
    ffca_pkg::t_status r_status;

    logic [FREE_ENTRIES-1:0] r_ext_valid;
    logic [LIVE_ENTRIES-1:0] r_live_valid;
    logic [STW-1:0]          r_stamp;

    // sweep scanner
    logic [SW-1:0]  r_cnt, r_didx;
    logic           r_dv;

    // captures
    logic           r_fit_found, r_slot_found, r_ls_found, r_lm_found, r_mg_found;
    logic [FAW-1:0] r_fit_idx, r_slot_idx, r_mg_idx, r_node;
    logic [LAW-1:0] r_ls_idx, r_lm_idx;
    logic [31:0]    r_fit_base, r_fit_len, r_lm_len, r_mg_base, r_mg_len, r_nb, r_nl;
    logic [STW-1:0] r_fit_stamp, r_mg_stamp;

    // size math
    logic [32:0] w_s1, w_s2, w_size;
    logic        w_size_err, w_add_err;
    logic [32:0] w_add_sum;
    logic [31:0] w_blk;
    logic        w_addr_ok;

    assign w_s1      = {1'b0, r_req} + 33'(HEADER_BYTES);
    assign w_s2      = (w_s1 + 33'd3) & ~33'd3;
    assign w_size    = (w_s2 < 33'(MIN_BLOCK_BYTES)) ? 33'(MIN_BLOCK_BYTES) : w_s2;
    assign w_size_err = (r_req == 32'd0) || w_size[32];
    assign w_add_sum = {1'b0, r_addr} + {1'b0, r_req};
    assign w_add_err = (r_req == 32'd0) || (w_add_sum[32] && (w_add_sum[31:0] != 32'd0));
    assign w_blk     = r_addr - 32'(HEADER_BYTES);
    assign w_addr_ok = (r_addr >= 32'(HEADER_BYTES));

    // memories
    logic           w_ext_we, w_live_we;
    logic [FAW-1:0] w_ext_waddr;
    logic [LAW-1:0] w_live_waddr;
    logic [EW-1:0]  w_ext_wdata, w_ext_rdata;
    logic [63:0]    w_live_wdata, w_live_rdata;

    ffca_ram #(.WIDTH(EW), .DEPTH(FREE_ENTRIES)) u_ext_ram (
        .i_clk   (i_clk),
        .i_we    (w_ext_we),
        .i_waddr (w_ext_waddr),
        .i_wdata (w_ext_wdata),
        .i_raddr (r_cnt[FAW-1:0]),
        .o_rdata (w_ext_rdata)
    );

    ffca_ram #(.WIDTH(64), .DEPTH(LIVE_ENTRIES)) u_live_ram (
        .i_clk   (i_clk),
        .i_we    (w_live_we),
        .i_waddr (w_live_waddr),
        .i_wdata (w_live_wdata),
        .i_raddr (r_cnt[LAW-1:0]),
        .o_rdata (w_live_rdata)
    );

    logic [STW-1:0] e_stamp;
    logic [31:0]    e_base, e_len, l_base, l_len;
    assign e_stamp = w_ext_rdata[EW-1:64];
    assign e_base  = w_ext_rdata[63:32];
    assign e_len   = w_ext_rdata[31:0];
    assign l_base  = w_live_rdata[63:32];
    assign l_len   = w_live_rdata[31:0];

    // per-entry tests on the sweep data
    logic [FAW-1:0] w_fi;
    logic [LAW-1:0] w_li;
    logic           e_in, e_v, l_in, l_v, adj;
    logic [32:0]    w_msum;
    logic           t_fit, t_mg, t_slot, t_ls, t_lm;

    always_comb begin
        w_fi   = r_didx[FAW-1:0];
        w_li   = r_didx[LAW-1:0];
        e_in   = r_dv && (r_didx < SW'(FREE_ENTRIES));
        e_v    = e_in && r_ext_valid[w_fi];
        l_in   = r_dv && (r_didx < SW'(LIVE_ENTRIES));
        l_v    = r_live_valid[w_li];
        if (e_base < r_nb) begin
            adj = (({1'b0, e_base} + {1'b0, e_len}) == {1'b0, r_nb});
        end else begin
            adj = (({1'b0, r_nb} + {1'b0, r_nl}) == {1'b0, e_base});
        end
        w_msum = {1'b0, r_nl} + {1'b0, e_len};
        t_fit  = e_v && (e_len >= r_size) && (!r_fit_found || (e_stamp > r_fit_stamp));
        t_mg   = e_v && (w_fi != r_node) && adj && !w_msum[32]
                 && (!r_mg_found || (e_stamp > r_mg_stamp));
        t_slot = e_in && !r_ext_valid[w_fi] && !r_slot_found;
        t_ls   = l_in && !l_v && !r_ls_found;
        t_lm   = l_in && l_v && w_addr_ok && (l_base == w_blk) && !r_lm_found;
    end

    // apply decisions
    logic        w_alloc_ok, w_free_ok, w_add_ok;
    logic [31:0] w_left;
    logic        w_lo_is_mg;
    logic [31:0] w_lo_base, w_mlen;
    logic [FAW-1:0] w_lo_idx, w_hi_idx;

    assign w_alloc_ok = (r_op == ffca_pkg::OP_ALLOC) && r_fit_found && r_ls_found;
    assign w_free_ok  = (r_op == ffca_pkg::OP_FREE) && r_lm_found && r_slot_found;
    assign w_add_ok   = (r_op == ffca_pkg::OP_ADD) && r_slot_found;
    assign w_left     = r_fit_len - r_size;
    assign w_lo_is_mg = (r_mg_base < r_nb);
    assign w_lo_base  = w_lo_is_mg ? r_mg_base : r_nb;
    assign w_lo_idx   = w_lo_is_mg ? r_mg_idx : r_node;
    assign w_hi_idx   = w_lo_is_mg ? r_node : r_mg_idx;
    assign w_mlen     = r_nl + r_mg_len;

    always_comb begin
        w_ext_we     = 1'b0;
        w_ext_waddr  = r_slot_idx;
        w_ext_wdata  = {r_stamp, r_addr, r_req};
        w_live_we    = 1'b0;
        w_live_waddr = r_ls_idx;
        w_live_wdata = {r_fit_base, r_size};
        if (i_cmd.apply) begin
            if (w_alloc_ok) begin
                w_ext_we    = (w_left != 32'd0);
                w_ext_waddr = r_fit_idx;
                w_ext_wdata = {r_stamp, r_fit_base + r_size, w_left};
                w_live_we   = 1'b1;
            end else if (w_free_ok) begin
                w_ext_we    = 1'b1;
                w_ext_wdata = {r_stamp, w_blk, r_lm_len};
            end else if (w_add_ok) begin
                w_ext_we    = 1'b1;
            end
        end else if (i_cmd.merge_apply && r_mg_found) begin
            w_ext_we    = 1'b1;
            w_ext_waddr = w_lo_idx;
            w_ext_wdata = {r_stamp, w_lo_base, w_mlen};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_valid  <= '0;
            r_live_valid <= '0;
            r_stamp      <= '0;
            r_cnt        <= '0;
            r_dv         <= 1'b0;
        end else begin
            if (i_cmd.sweep_start) begin
                r_cnt <= '0;
                r_dv  <= 1'b0;
            end else if (i_cmd.sweep_run) begin
                if (r_cnt != SW'(SWEEP_N)) begin
                    r_cnt <= r_cnt + 1'b1;
                    r_dv  <= 1'b1;
                end else begin
                    r_dv <= 1'b0;
                end
            end
            if (i_cmd.apply) begin
                if (w_alloc_ok) begin
                    r_live_valid[r_ls_idx] <= 1'b1;
                    if (w_left == 32'd0) begin
                        r_ext_valid[r_fit_idx] <= 1'b0;
                    end else begin
                        r_stamp <= r_stamp + 1'b1;
                    end
                end else if (w_free_ok) begin
                    r_ext_valid[r_slot_idx] <= 1'b1;
                    r_live_valid[r_lm_idx]  <= 1'b0;
                    r_stamp                 <= r_stamp + 1'b1;
                end else if (w_add_ok) begin
                    r_ext_valid[r_slot_idx] <= 1'b1;
                    r_stamp                 <= r_stamp + 1'b1;
                end
            end
            if (i_cmd.merge_apply && r_mg_found) begin
                r_ext_valid[w_hi_idx] <= 1'b0;
                r_stamp               <= r_stamp + 1'b1;
            end
        end
    end

    // payload and capture registers
    always_ff @(posedge i_clk) begin
        r_didx <= r_cnt;
        if (i_cmd.load) begin
            r_op     <= ffca_pkg::t_op'(i_operation);
            r_req    <= i_request_bytes;
            r_addr   <= i_address;
            r_res    <= 32'd0;
            r_status <= ffca_pkg::ST_OK;
        end
        if (i_cmd.check) begin
            r_size <= w_size[31:0];
            if (o_stat.pre_err) begin
                r_status <= ffca_pkg::ST_SIZE;
            end
        end
        if (i_cmd.sweep_start) begin
            r_fit_found  <= 1'b0;
            r_slot_found <= 1'b0;
            r_ls_found   <= 1'b0;
            r_lm_found   <= 1'b0;
            r_mg_found   <= 1'b0;
        end else if (i_cmd.sweep_run) begin
            if (t_fit) begin
                r_fit_found <= 1'b1;
                r_fit_idx   <= w_fi;
                r_fit_base  <= e_base;
                r_fit_len   <= e_len;
                r_fit_stamp <= e_stamp;
            end
            if (t_mg) begin
                r_mg_found <= 1'b1;
                r_mg_idx   <= w_fi;
                r_mg_base  <= e_base;
                r_mg_len   <= e_len;
                r_mg_stamp <= e_stamp;
            end
            if (t_slot) begin
                r_slot_found <= 1'b1;
                r_slot_idx   <= w_fi;
            end
            if (t_ls) begin
                r_ls_found <= 1'b1;
                r_ls_idx   <= w_li;
            end
            if (t_lm) begin
                r_lm_found <= 1'b1;
                r_lm_idx   <= w_li;
                r_lm_len   <= l_len;
            end
        end
        if (i_cmd.apply) begin
            case (r_op)
                ffca_pkg::OP_ALLOC: begin
                    if (!r_fit_found) begin
                        r_status <= ffca_pkg::ST_NOFIT;
                    end else if (!r_ls_found) begin
                        r_status <= ffca_pkg::ST_FULL;
                    end else begin
                        r_res <= r_fit_base + 32'(HEADER_BYTES);
                    end
                end
                ffca_pkg::OP_FREE: begin
                    if (!r_lm_found) begin
                        r_status <= ffca_pkg::ST_BADPTR;
                    end else if (!r_slot_found) begin
                        r_status <= ffca_pkg::ST_FULL;
                    end else begin
                        r_node <= r_slot_idx;
                        r_nb   <= w_blk;
                        r_nl   <= r_lm_len;
                    end
                end
                ffca_pkg::OP_ADD: begin
                    if (!r_slot_found) begin
                        r_status <= ffca_pkg::ST_FULL;
                    end
                end
                default: r_status <= r_status;
            endcase
        end
        if (i_cmd.merge_apply && r_mg_found) begin
            r_node <= w_lo_idx;
            r_nb   <= w_lo_base;
            r_nl   <= w_mlen;
        end
    end

    always_comb begin
        o_stat.op         = r_op;
        o_stat.pre_err    = ((r_op == ffca_pkg::OP_ALLOC) && w_size_err)
                            || ((r_op == ffca_pkg::OP_ADD) && w_add_err);
        o_stat.sweep_done = (r_cnt == SW'(SWEEP_N)) && !r_dv;
        o_stat.go_merge   = w_free_ok;
    end

    assign o_result_address = r_res;
    assign o_status         = r_status;
endmodule

@@ rtl/first_fit_coalescing_allocator_core.sv @@
// Top level of the first-fit heap allocator with coalescing on free.
// Input channel: i_in_valid / o_in_stall carry one item (operation, request
// bytes, address). An item is taken when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall carry one result item (user
// pointer, status) for every input item.
// Flow: the block works on one item at a time. Unknown operations and size
// errors go from the check straight to the result. Allocate and add make one
// sweep over N = max(FREE_ENTRIES, LIVE_ENTRIES) table entries, read one entry
// a cycle through the registered port of each table RAM. A successful free
// adds two merge sweeps over the extent table.
// Reset clears both valid-bit vectors at once: the tables are empty and the
// block can take an item as soon as reset is released. Table contents are not
// cleared. While the receiver stalls, the result holds on the output ports
// and the input stays stalled.
`timescale 1ns / 1ps
`include "first_fit_coalescing_allocator_core_macros.svh"
module first_fit_coalescing_allocator_core #(
    parameter int FREE_ENTRIES    = ffca_pkg::FREE_ENTRIES_DEF,
    parameter int LIVE_ENTRIES    = ffca_pkg::LIVE_ENTRIES_DEF,
    parameter int HEADER_BYTES    = ffca_pkg::HEADER_BYTES_DEF,
    parameter int MIN_BLOCK_BYTES = ffca_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_request_bytes,
    input  logic [31:0] i_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_result_address,
    output logic [2:0]  o_status
);
    ffca_pkg::t_cmd  w_cmd;
    ffca_pkg::t_stat w_stat;

    ffca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ffca_dp #(
        .FREE_ENTRIES    (FREE_ENTRIES),
        .LIVE_ENTRIES    (LIVE_ENTRIES),
        .HEADER_BYTES    (HEADER_BYTES),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_operation      (i_operation),
        .i_request_bytes  (i_request_bytes),
        .i_address        (i_address),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_result_address (o_result_address),
        .o_status         (o_status)
    );

    // a result never shows while the input side is open
    `FFCA_ASSERT_NOW(a_out_blocks_in, o_out_valid, o_in_stall)
    // an accepted item never yields a result in the very next cycle
    `FFCA_ASSERT_NEXT(a_no_instant_result, i_in_valid && !o_in_stall, !o_out_valid)
    // a returned pointer only comes with a good status
    `FFCA_ASSERT_NOW(a_ptr_ok, o_out_valid && (o_result_address != 32'd0),
                     o_status == ffca_pkg::ST_OK)
endmodule

@@ verif/first_fit_coalescing_allocator_core_tb.sv @@
// Self-checking testbench for the first-fit coalescing allocator core.
`timescale 1ns / 1ps
module first_fit_coalescing_allocator_core_tb;

    localparam int NFREE = 64;
    localparam int NLIVE = 64;
    localparam int HDR = 8;
    localparam int MINBLK = 8;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        ffca_pkg::t_op op;
        logic [31:0]   req;
        logic [31:0]   addr;
    } t_item;

    typedef struct packed {
        logic [31:0]       ptr;
        ffca_pkg::t_status st;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_operation;
    logic [31:0] i_request_bytes;
    logic [31:0] i_address;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_result_address;
    logic [2:0]  o_status;

    first_fit_coalescing_allocator_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_operation(i_operation), .i_request_bytes(i_request_bytes),
        .i_address(i_address),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_result_address(o_result_address), .o_status(o_status)
    );

    // Heap mirror.
    logic [31:0] ext_base [NFREE];
    logic [31:0] ext_len  [NFREE];
    logic        ext_vld  [NFREE];
    int unsigned ext_rank [NFREE];
    logic [31:0] blk_base [NLIVE];
    logic [31:0] blk_len  [NLIVE];
    logic        blk_vld  [NLIVE];

    t_item       pending_items[$];
    t_answer     expected_answers[$];
    logic [31:0] issued_ptrs[$];
    int          mismatches = 0;
    int          sent = 0;
    int          idle_in_pct = 0;
    int          idle_out_pct = 0;
    int          quiet_cycles = 0;
    bit          stim_done = 0;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic void push_head(int s);
        for (int i = 0; i < NFREE; i++)
            if (ext_vld[i]) ext_rank[i]++;
        ext_rank[s] = 0;
        ext_vld[s] = 1'b1;
    endfunction

    function automatic void unlink(int s);
        int unsigned r;
        r = ext_rank[s];
        ext_vld[s] = 1'b0;
        for (int i = 0; i < NFREE; i++)
            if (ext_vld[i] && ext_rank[i] > r) ext_rank[i]--;
    endfunction

    function automatic int empty_ext_slot();
        for (int i = 0; i < NFREE; i++)
            if (!ext_vld[i]) return i;
        return -1;
    endfunction

    function automatic int coalesce(int node);
        int pick;
        int unsigned best;
        logic [32:0] nb, nl, cb, cl;
        bit adj;
        int lo, hi;
        pick = -1;
        best = 32'hFFFF_FFFF;
        for (int i = 0; i < NFREE; i++) begin
            if (!ext_vld[i] || i == node) continue;
            nb = ext_base[node]; nl = ext_len[node];
            cb = ext_base[i];    cl = ext_len[i];
            adj = (cb < nb) ? (cb + cl == nb) : (nb + nl == cb);
            if (adj && nl + cl <= 33'hFFFF_FFFF && ext_rank[i] < best) begin
                best = ext_rank[i];
                pick = i;
            end
        end
        if (pick < 0) return node;
        lo = node; hi = pick;
        if (ext_base[pick] < ext_base[node]) begin
            lo = pick; hi = node;
        end
        unlink(hi);
        unlink(lo);
        ext_len[lo] += ext_len[hi];
        push_head(lo);
        return lo;
    endfunction

    function automatic t_answer heap_step(t_item it);
        t_answer a;
        logic [33:0] size;
        int pick, ls, s;
        int unsigned best;
        logic [31:0] b;
        a.ptr = '0;
        a.st = ffca_pkg::ST_OK;
        case (it.op)
            ffca_pkg::OP_ALLOC: begin
                size = ({2'b0, it.req} + HDR + 3) & ~34'd3;
                if (size < MINBLK) size = MINBLK;
                if (it.req == 0 || size > 34'hFFFF_FFFF) begin
                    a.st = ffca_pkg::ST_SIZE;
                end else begin
                    pick = -1; ls = -1; best = 32'hFFFF_FFFF;
                    for (int i = 0; i < NFREE; i++)
                        if (ext_vld[i] && ext_len[i] >= size && ext_rank[i] < best) begin
                            best = ext_rank[i];
                            pick = i;
                        end
                    for (int i = 0; i < NLIVE; i++)
                        if (!blk_vld[i] && ls < 0) ls = i;
                    if (pick < 0) a.st = ffca_pkg::ST_NOFIT;
                    else if (ls < 0) a.st = ffca_pkg::ST_FULL;
                    else begin
                        b = ext_base[pick];
                        unlink(pick);
                        if (ext_len[pick] != size[31:0]) begin
                            ext_len[pick] = ext_len[pick] - size[31:0];
                            ext_base[pick] = b + size[31:0];
                            push_head(pick);
                        end
                        blk_base[ls] = b;
                        blk_len[ls] = size[31:0];
                        blk_vld[ls] = 1'b1;
                        a.ptr = b + HDR;
                    end
                end
            end
            ffca_pkg::OP_FREE: begin
                ls = -1;
                if (it.addr >= HDR)
                    for (int i = 0; i < NLIVE; i++)
                        if (ls < 0 && blk_vld[i] && blk_base[i] == it.addr - HDR) ls = i;
                if (ls < 0) a.st = ffca_pkg::ST_BADPTR;
                else begin
                    s = empty_ext_slot();
                    if (s < 0) a.st = ffca_pkg::ST_FULL;
                    else begin
                        ext_base[s] = blk_base[ls];
                        ext_len[s] = blk_len[ls];
                        blk_vld[ls] = 1'b0;
                        push_head(s);
                        s = coalesce(s);
                        void'(coalesce(s));
                    end
                end
            end
            ffca_pkg::OP_ADD: begin
                if (it.req == 0 || {1'b0, it.addr} + {1'b0, it.req} > 33'h1_0000_0000)
                    a.st = ffca_pkg::ST_SIZE;
                else begin
                    s = empty_ext_slot();
                    if (s < 0) a.st = ffca_pkg::ST_FULL;
                    else begin
                        ext_base[s] = it.addr;
                        ext_len[s] = it.req;
                        push_head(s);
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
                t_item it;
                it = pending_items.pop_front();
                expected_answers.push_back(heap_step(it));
                if (it.op == ffca_pkg::OP_ALLOC && expected_answers[$].st == ffca_pkg::ST_OK)
                    issued_ptrs.push_back(expected_answers[$].ptr);
                i_in_valid <= 1'b1;
                i_operation <= it.op;
                i_request_bytes <= it.req;
                i_address <= it.addr;
                sent++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            i_out_stall <= ($urandom_range(99) < idle_out_pct);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (o_out_valid && !i_out_stall) begin
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result ptr=%h st=%0d", o_result_address, o_status);
                end else begin
                    t_answer e;
                    e = expected_answers.pop_front();
                    if (e.ptr !== o_result_address || e.st !== o_status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected ptr=%h st=%0d, got ptr=%h st=%0d",
                                     e.ptr, e.st, o_result_address, o_status);
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic t_item mk(ffca_pkg::t_op op, logic [31:0] req, logic [31:0] addr);
        t_item it;
        it.op = op; it.req = req; it.addr = addr;
        return it;
    endfunction

    // Pointer to free: mostly a real one, sometimes junk.
    function automatic logic [31:0] pick_ptr();
        int k;
        logic [31:0] p;
        if (issued_ptrs.size() > 0 && $urandom_range(9) < 8) begin
            k = $urandom_range(issued_ptrs.size() - 1);
            p = issued_ptrs[k];
            issued_ptrs.delete(k);
            return p;
        end
        return $urandom_range(3) == 0 ? $urandom() : $urandom_range(64);
    endfunction

    task automatic run_phase(int n, int in_pct, int out_pct);
        idle_in_pct = in_pct;
        idle_out_pct = out_pct;
        for (int i = 0; i < n; i++) begin
            int r;
            t_item it;
            // hold off so free pointers come from the current heap state
            while (pending_items.size() > 2) @(posedge i_clk);
            r = $urandom_range(99);
            if (r < 45) begin
                it = mk(ffca_pkg::OP_ALLOC, $urandom_range(9) == 0 ? $urandom() :
                        $urandom_range(300), 0);
            end else if (r < 85) begin
                it = mk(ffca_pkg::OP_FREE, $urandom(), pick_ptr());
            end else if (r < 96) begin
                it = mk(ffca_pkg::OP_ADD, $urandom_range(1, 4096),
                        {4'($urandom_range(15)), 16'h0, 2'($urandom_range(3)), 2'b0, 8'h0});
                if ($urandom_range(7) == 0) begin
                    it.req = $urandom(); it.addr = $urandom();
                end
            end else begin
                it = mk(ffca_pkg::OP_NONE, $urandom(), $urandom());
            end
            pending_items.push_back(it);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_operation = ffca_pkg::OP_NONE;
        i_request_bytes = '0;
        i_address = '0;
        for (int i = 0; i < NFREE; i++) begin
            ext_vld[i] = 0; ext_base[i] = 0; ext_len[i] = 0; ext_rank[i] = 0;
        end
        for (int i = 0; i < NLIVE; i++) begin
            blk_vld[i] = 0; blk_base[i] = 0; blk_len[i] = 0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: errors, extremes, splits, merges, overflow merges.
        pending_items.push_back(mk(ffca_pkg::OP_ALLOC, 32'd0, 0));
        pending_items.push_back(mk(ffca_pkg::OP_ALLOC, 32'd16, 0));
        pending_items.push_back(mk(ffca_pkg::OP_FREE, 0, 32'd0));
        pending_items.push_back(mk(ffca_pkg::OP_FREE, 0, 32'd7));
        pending_items.push_back(mk(ffca_pkg::OP_ADD, 32'd0, 32'h100));
        pending_items.push_back(mk(ffca_pkg::OP_ADD, 32'h10, 32'hFFFF_FFF8));
        pending_items.push_back(mk(ffca_pkg::OP_ADD, 32'h8, 32'hFFFF_FFF8));
        pending_items.push_back(mk(ffca_pkg::OP_ALLOC, 32'hFFFF_FFFF, 0));
        pending_items.push_back(mk(ffca_pkg::OP_ALLOC, 32'hFFFF_FFF4, 0));
        pending_items.push_back(mk(ffca_pkg::OP_ADD, 32'h1000, 32'h1000));
        pending_items.push_back(mk(ffca_pkg::OP_ALLOC, 32'd1, 0));
        pending_items.push_back(mk(ffca_pkg::OP_ALLOC, 32'd13, 0));
        pending_items.push_back(mk(ffca_pkg::OP_ALLOC, 32'd100, 0));
        pending_items.push_back(mk(ffca_pkg::OP_FREE, 0, 32'h1018));
        pending_items.push_back(mk(ffca_pkg::OP_FREE, 0, 32'h1008));
        pending_items.push_back(mk(ffca_pkg::OP_FREE, 0, 32'h1028));
        pending_items.push_back(mk(ffca_pkg::OP_FREE, 0, 32'h1028));
        pending_items.push_back(mk(ffca_pkg::OP_ALLOC, 32'h2000, 0));
        pending_items.push_back(mk(ffca_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_items.push_back(mk(ffca_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h0));
        pending_items.push_back(mk(ffca_pkg::OP_ADD, 32'h1, 32'hFFFF_FFFF));
        pending_items.push_back(mk(ffca_pkg::OP_ALLOC, 32'hFFFF_FFEF, 0));
        pending_items.push_back(mk(ffca_pkg::OP_FREE, 0, 32'h8));
        // fill the extent table, then fill the live table
        for (int i = 0; i < 66; i++)
            pending_items.push_back(mk(ffca_pkg::OP_ADD, 32'h40, 32'h2000_0000 + i * 32'h80));
        while (pending_items.size() > 0) @(posedge i_clk);
        for (int i = 0; i < 66; i++)
            pending_items.push_back(mk(ffca_pkg::OP_ALLOC, 32'd4, 0));

        run_phase(565, 15, 64);
        run_phase(565, 64, 15);
        run_phase(565, 0, 0);

        while (pending_items.size() > 0 || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl
rtl/ffca_pkg.sv
rtl/ffca_ram.sv
rtl/ffca_ctrl.sv
rtl/ffca_dp.sv
rtl/first_fit_coalescing_allocator_core.sv
verif/first_fit_coalescing_allocator_core_tb.sv
